/* rtl/pngunf_pkg.sv */
package pngunf_pkg;

  localparam int BYTE_W              = 8;
  localparam int ROW_PIXELS_W        = 13;
  localparam int BPP_W               = 3;
  localparam int CFG_DATA_W          = 13;
  localparam int CFG_IDX_W           = 1;
  localparam int DEF_MAX_ROW_PIXELS  = 4096;
  localparam int DEF_MAX_BPP         = 4;
  localparam int FILTER_MAX_CODE     = 4;

  // Row filter types. Anything above Paeth in the stream is kept as the invalid code.
  typedef enum logic [2:0] {
    FILT_NONE    = 3'd0,
    FILT_SUB     = 3'd1,
    FILT_UP      = 3'd2,
    FILT_AVG     = 3'd3,
    FILT_PAETH   = 3'd4,
    FILT_INVALID = 3'd5
  } filter_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_PIXELS = 1'b0,
    CFG_BPP        = 1'b1
  } cfg_idx_t;

  // Left, above and upper-left neighbors of the byte being reconstructed.
  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
  } nbr_t;

endpackage

/* rtl/pngunf_ram.sv */
module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/pngunf_predict.sv */
module pngunf_predict (
  input  pngunf_pkg::filter_t          filt,
  input  pngunf_pkg::nbr_t             nbr,
  input  logic [pngunf_pkg::BYTE_W-1:0] x,
  output logic [pngunf_pkg::BYTE_W-1:0] result
);
  import pngunf_pkg::*;

  logic [BYTE_W:0]   avg_sum;
  logic signed [9:0] d_pa;
  logic signed [9:0] d_pb;
  logic signed [9:0] d_pc;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [BYTE_W-1:0] paeth;
  logic [BYTE_W-1:0] pred;

  always_comb begin
    avg_sum = {1'b0, nbr.a} + {1'b0, nbr.b};

    d_pa = $signed({2'b00, nbr.b}) - $signed({2'b00, nbr.c});
    d_pb = $signed({2'b00, nbr.a}) - $signed({2'b00, nbr.c});
    d_pc = $signed({2'b00, nbr.a}) + $signed({2'b00, nbr.b})
         - $signed({1'b0, nbr.c, 1'b0});
    pa = d_pa[9] ? 10'(-d_pa) : 10'(d_pa);
    pb = d_pb[9] ? 10'(-d_pb) : 10'(d_pb);
    pc = d_pc[9] ? 10'(-d_pc) : 10'(d_pc);

    // Ties go to the left byte first, then to the byte above.
    if (pa <= pb && pa <= pc) begin
      paeth = nbr.a;
    end else if (pb <= pc) begin
      paeth = nbr.b;
    end else begin
      paeth = nbr.c;
    end

    case (filt)
      FILT_SUB:   pred = nbr.a;
      FILT_UP:    pred = nbr.b;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: pred = paeth;
      default:    pred = '0;
    endcase

    result = x + pred;
  end

endmodule

/* rtl/png_scanline_unfilter.sv */
// Channel  Direction  Payload                                        Handshake
// in_      input      in_byte, in_image_start                        in_valid / in_ready
// out_     output     out_pixel_byte, out_row_last, out_bad_filter   out_valid / out_ready
// cfg_     input      cfg_index, cfg_data                            cfg_valid / cfg_ready
//
// One word is taken per cycle while in_ready is high. A word sits in the input stage, where
// the line store read started at acceptance returns the byte above, and its result then
// lands in the output register; a new word can be taken as the last one leaves the input stage.
// Filter type words produce no result. Reset is synchronous and needs no clearing pass:
// the first row of an image never uses the byte read from the line store. A stalled output
// holds the input stage, and in_ready follows out_ready only while that stage holds a sample
// byte and the output register is full.
module png_scanline_unfilter #(
  parameter int MAX_ROW_PIXELS      = pngunf_pkg::DEF_MAX_ROW_PIXELS,
  parameter int MAX_BYTES_PER_PIXEL = pngunf_pkg::DEF_MAX_BPP
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pngunf_pkg::BYTE_W-1:0]     in_byte,
  input  logic                              in_image_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pngunf_pkg::BYTE_W-1:0]     out_pixel_byte,
  output logic                              out_row_last,
  output logic                              out_bad_filter,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pngunf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pngunf_pkg::*;

  localparam int DEPTH  = MAX_ROW_PIXELS * MAX_BYTES_PER_PIXEL;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RB_W   = $clog2(DEPTH + 1);
  localparam int PIX_W  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int BPPV_W = $clog2(MAX_BYTES_PER_PIXEL + 1);
  localparam int LANE_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

  // Configuration.
  logic [ROW_PIXELS_W-1:0] row_pixels_r;
  logic [BPP_W-1:0]        bpp_r;
  logic [PIX_W-1:0]        eff_pix;
  logic [BPPV_W-1:0]       eff_bpp;
  logic [RB_W-1:0]         row_bytes;

  // Input stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_start_r;

  // Row position state.
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic              first_row_r, first_row_nxt;
  filter_t           filter_r, filter_nxt;
  logic              restart;

  // One column counter for every possible pixel size, so that the channel index stays
  // right even when the pixel size is changed in the middle of a row.
  logic [LANE_W-1:0] lane_r   [MAX_BYTES_PER_PIXEL];
  logic [LANE_W-1:0] lane_nxt [MAX_BYTES_PER_PIXEL];
  logic [LANE_W-1:0] k;

  logic [BYTE_W-1:0] left_r [MAX_BYTES_PER_PIXEL];
  logic [BYTE_W-1:0] ul_r   [MAX_BYTES_PER_PIXEL];

  // Output register.
  logic              out_valid_r;
  logic [BYTE_W-1:0] pixel_r;
  logic              last_r;
  logic              bad_r;

  logic              is_filt;
  logic              s1_fire;
  logic              data_fire;
  logic              in_fire;
  logic              past_first_pixel;
  logic              row_end;
  logic [BYTE_W-1:0] above;
  logic [BYTE_W-1:0] result;
  nbr_t              nbr;
  filter_t           new_filter;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (row_pixels_r == '0) begin
      eff_pix = PIX_W'(1);
    end else if (32'(row_pixels_r) > MAX_ROW_PIXELS) begin
      eff_pix = PIX_W'(MAX_ROW_PIXELS);
    end else begin
      eff_pix = PIX_W'(row_pixels_r);
    end
    if (bpp_r == '0) begin
      eff_bpp = BPPV_W'(1);
    end else if (32'(bpp_r) > MAX_BYTES_PER_PIXEL) begin
      eff_bpp = BPPV_W'(MAX_BYTES_PER_PIXEL);
    end else begin
      eff_bpp = BPPV_W'(bpp_r);
    end
  end

  assign row_bytes = RB_W'(eff_pix) * RB_W'(eff_bpp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pixels_r <= ROW_PIXELS_W'(1);
      bpp_r        <= BPP_W'(1);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROW_PIXELS: row_pixels_r <= cfg_data[ROW_PIXELS_W-1:0];
          CFG_BPP:        bpp_r        <= cfg_data[BPP_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  assign is_filt   = s1_start_r | awaiting_r;
  assign s1_fire   = s1_valid_r & (is_filt | ~out_valid_r | out_ready);
  assign data_fire = s1_fire & ~is_filt;
  assign in_ready  = ~s1_valid_r | s1_fire;
  assign in_fire   = in_valid & in_ready;

  assign k                = lane_r[LANE_W'(eff_bpp - BPPV_W'(1))];
  assign past_first_pixel = 32'(col_r) >= 32'(eff_bpp);
  assign row_end          = (32'(col_r) + 32'd1) >= 32'(row_bytes);

  assign new_filter = (32'(s1_byte_r) > FILTER_MAX_CODE) ? FILT_INVALID
                                                          : filter_t'(s1_byte_r[2:0]);

  always_comb begin
    col_nxt       = col_r;
    awaiting_nxt  = awaiting_r;
    first_row_nxt = first_row_r;
    filter_nxt    = filter_r;
    restart       = 1'b0;
    if (s1_fire) begin
      if (is_filt) begin
        filter_nxt   = new_filter;
        awaiting_nxt = 1'b0;
        col_nxt      = '0;
        restart      = 1'b1;
        if (s1_start_r) begin
          first_row_nxt = 1'b1;
        end
      end else if (row_end) begin
        col_nxt       = '0;
        awaiting_nxt  = 1'b1;
        first_row_nxt = 1'b0;
        restart       = 1'b1;
      end else begin
        col_nxt = col_r + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    for (int m = 0; m < MAX_BYTES_PER_PIXEL; m++) begin
      if (restart) begin
        lane_nxt[m] = '0;
      end else if (data_fire) begin
        lane_nxt[m] = (lane_r[m] == LANE_W'(m)) ? '0 : lane_r[m] + LANE_W'(1);
      end else begin
        lane_nxt[m] = lane_r[m];
      end
    end
  end

  // The byte above is read at the column the accepted word will land on.
  pngunf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (data_fire),
    .wr_addr (col_r),
    .wr_data (result),
    .rd_en   (in_fire),
    .rd_addr (col_nxt),
    .rd_data (above)
  );

  always_comb begin
    nbr.a = past_first_pixel ? left_r[k] : '0;
    nbr.b = first_row_r ? '0 : above;
    nbr.c = (past_first_pixel && !first_row_r) ? ul_r[k] : '0;
  end

  pngunf_predict u_predict (
    .filt   (filter_r),
    .nbr    (nbr),
    .x      (s1_byte_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      awaiting_r  <= 1'b1;
      first_row_r <= 1'b1;
      filter_r    <= FILT_NONE;
      for (int m = 0; m < MAX_BYTES_PER_PIXEL; m++) begin
        lane_r[m] <= '0;
        left_r[m] <= '0;
        ul_r[m]   <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (data_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      col_r       <= col_nxt;
      awaiting_r  <= awaiting_nxt;
      first_row_r <= first_row_nxt;
      filter_r    <= filter_nxt;
      for (int m = 0; m < MAX_BYTES_PER_PIXEL; m++) begin
        lane_r[m] <= lane_nxt[m];
      end
      if (data_fire) begin
        left_r[k] <= result;
        ul_r[k]   <= nbr.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_byte;
      s1_start_r <= in_image_start;
    end
    if (data_fire) begin
      pixel_r   <= result;
      last_r    <= row_end;
      bad_r     <= (filter_r == FILT_INVALID);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = pixel_r;
  assign out_row_last   = last_r;
  assign out_bad_filter = bad_r;

endmodule

/* bench/png_scanline_unfilter_test.sv */
module png_scanline_unfilter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pngunf_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_ROW_PIXELS * DEF_MAX_BPP;
  localparam int LATENCY     = 2;
  localparam int IDLE_PCT    = 30;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              row_last;
    logic              bad_filter;
  } pixel_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte = '0;
  logic                  in_image_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_pixel_byte;
  logic                  out_row_last;
  logic                  out_bad_filter;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROW_PIXELS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block's state, advanced at every accepted input word.
  logic [BYTE_W-1:0]       prior_row [STORE_DEPTH];
  bit                      row_written [STORE_DEPTH];
  logic [BYTE_W-1:0]       left_hist [DEF_MAX_BPP] = '{default: '0};
  logic [BYTE_W-1:0]       upleft_hist [DEF_MAX_BPP] = '{default: '0};
  int                      column = 0;
  filter_t                 row_filter = FILT_NONE;
  bit                      want_filter = 1'b1;
  bit                      first_row = 1'b1;
  logic [ROW_PIXELS_W-1:0] cfg_row_pixels = ROW_PIXELS_W'(1);
  logic [BPP_W-1:0]        cfg_bpp = BPP_W'(1);

  pixel_word_t pending_pixels [$];
  int          mismatch_count = 0;
  int          words_checked = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  bit          holding = 1'b0;
  event        hold_results;

  png_scanline_unfilter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_image_start (in_image_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_byte (out_pixel_byte),
    .out_row_last   (out_row_last),
    .out_bad_filter (out_bad_filter),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (holding) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always begin
    @(hold_results);
    holding <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    holding <= 1'b0;
  end

  function automatic int active_bpp();
    if (cfg_bpp == 0) return 1;
    if (cfg_bpp > DEF_MAX_BPP) return DEF_MAX_BPP;
    return int'(cfg_bpp);
  endfunction

  function automatic int paeth_pick(input int a, input int b, input int c);
    int pa, pb, pc;
    pa = (b > c) ? b - c : c - b;
    pb = (a > c) ? a - c : c - a;
    pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // True when the next data word would read a line store entry never written.
  function automatic bit reads_unwritten();
    int col;
    col = (column >= STORE_DEPTH) ? STORE_DEPTH - 1 : column;
    return !want_filter && !first_row && !row_written[col];
  endfunction

  function automatic void reconstruct_byte(input logic [BYTE_W-1:0] x, input logic start);
    int bpp, pixels, row_len, col, k, a, b, c, pred;
    logic [BYTE_W-1:0] res;
    logic last;
    if (start) begin
      want_filter = 1'b1;
      first_row = 1'b1;
      column = 0;
    end
    if (want_filter) begin
      row_filter = (x > FILTER_MAX_CODE) ? FILT_INVALID : filter_t'(x[2:0]);
      want_filter = 1'b0;
      column = 0;
      return;
    end
    bpp = active_bpp();
    pixels = (cfg_row_pixels == 0) ? 1 :
             (cfg_row_pixels > DEF_MAX_ROW_PIXELS) ? DEF_MAX_ROW_PIXELS : int'(cfg_row_pixels);
    row_len = pixels * bpp;
    col = (column >= STORE_DEPTH) ? STORE_DEPTH - 1 : column;
    k = col % bpp;
    a = (col >= bpp) ? int'(left_hist[k]) : 0;
    b = first_row ? 0 : int'(prior_row[col]);
    c = (col >= bpp && !first_row) ? int'(upleft_hist[k]) : 0;
    case (row_filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = (a + b) >> 1;
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 0;
    endcase
    res = 8'(x + pred);
    upleft_hist[k] = 8'(b);
    left_hist[k] = res;
    prior_row[col] = res;
    row_written[col] = 1'b1;
    last = (col + 1 >= row_len);
    if (last) begin
      column = 0;
      want_filter = 1'b1;
      first_row = 1'b0;
    end else begin
      column = col + 1;
    end
    pending_pixels.push_back('{res, last, row_filter == FILT_INVALID});
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want_v);
    $display("%0t: word %0d, %s: got %0d, expected %0d", $time, words_checked, what, got,
             want_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    pixel_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("word with none expected", int'(out_pixel_byte), -1);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_byte !== want.value)
          report_mismatch("pixel_byte", int'(out_pixel_byte), int'(want.value));
        if (out_row_last !== want.row_last)
          report_mismatch("row_last", int'(out_row_last), int'(want.row_last));
        if (out_bad_filter !== want.bad_filter)
          report_mismatch("bad_filter", int'(out_bad_filter), int'(want.bad_filter));
      end
      words_checked++;
    end
  end

  // Valid stays high after an accepted word; the next call either replaces the
  // payload in the same step or first drops valid while it idles.
  task automatic send_byte(input logic [BYTE_W-1:0] x, input logic start);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= x;
    in_image_start <= start;
    do @(posedge clk); while (!in_ready);
    reconstruct_byte(x, start);
  endtask

  task automatic send_row(input logic [BYTE_W-1:0] code, input logic start, input int count);
    send_byte(code, start);
    repeat (count) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROW_PIXELS) cfg_row_pixels = value[ROW_PIXELS_W-1:0];
    else cfg_bpp = value[BPP_W-1:0];
  endtask

  // Reset registers give one-byte rows: every filter on the smallest row.
  task automatic test_default_row();
    send_byte(8'(FILT_NONE), 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'(FILT_SUB), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'(FILT_UP), 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'(FILT_AVG), 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'(FILT_PAETH), 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'(FILTER_MAX_CODE + 1), 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'haa, 1'b0);
    wait_idle();
  endtask

  task automatic test_each_filter();
    filter_t row_order [5] = '{FILT_NONE, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH};
    write_register(CFG_ROW_PIXELS, 2);
    write_register(CFG_BPP, 1);
    foreach (row_order[r]) begin
      send_byte(8'(row_order[r]), r == 0);
      send_byte(8'hff ^ 8'(r * 37), 1'b0);
      send_byte(8'h80 ^ 8'(r * 91), 1'b0);
    end
    send_byte(8'hc8, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hed, 1'b0);
    wait_idle();
  endtask

  // A new image in mid-row drops the partial row and starts over on a first row.
  task automatic test_image_restart();
    write_register(CFG_ROW_PIXELS, 3);
    send_row(8'(FILT_SUB), 1'b1, 2);
    send_row(8'(FILT_UP), 1'b1, 3);
    send_row(8'(FILT_AVG), 1'b0, 3);
    wait_idle();
  endtask

  // Rows at the largest sizes are only started here; a fresh image cuts all but the last short.
  task automatic test_register_limits();
    write_register(CFG_ROW_PIXELS, 0);
    write_register(CFG_BPP, 7);
    send_row(8'(FILT_SUB), 1'b1, 4);
    send_row(8'(FILT_PAETH), 1'b0, 4);
    write_register(CFG_ROW_PIXELS, 8191);
    write_register(CFG_BPP, 0);
    send_row(8'(FILT_AVG), 1'b1, 100);
    write_register(CFG_ROW_PIXELS, CFG_DATA_W'(DEF_MAX_ROW_PIXELS));
    write_register(CFG_BPP, CFG_DATA_W'(DEF_MAX_BPP));
    send_row(8'(FILT_SUB), 1'b1, 100);
    send_row(8'(FILT_PAETH), 1'b1, 20);
    wait_idle();
  endtask

  // Register changes take effect at once, even part way through a row.
  task automatic test_midrow_registers();
    write_register(CFG_ROW_PIXELS, 4);
    write_register(CFG_BPP, 1);
    send_row(8'(FILT_SUB), 1'b1, 3);
    write_register(CFG_ROW_PIXELS, 2);
    send_byte(8'($urandom), 1'b0);
    send_row(8'(FILT_UP), 1'b0, 2);
    send_row(8'(FILT_PAETH), 1'b0, 1);
    write_register(CFG_BPP, 2);
    repeat (3) send_byte(8'($urandom), 1'b0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    quiet <= 1'b1;
    write_register(CFG_ROW_PIXELS, 100);
    write_register(CFG_BPP, 1);
    -> hold_results;
    send_row(8'(FILT_SUB), 1'b1, 100);
    send_row(8'(FILT_PAETH), 1'b0, 20);
    wait_idle();
    repeat (80) send_byte(8'($urandom), 1'b0);
    wait_idle();
  endtask

  task automatic test_random_streams();
    int sent;
    int burst;
    logic [BYTE_W-1:0] x;
    logic start;
    sent = 0;
    while (sent < 500) begin
      quiet <= (sent >= 200 && sent < 300);
      if ($urandom_range(3) == 0) begin
        write_register(CFG_ROW_PIXELS, ($urandom_range(9) == 0) ?
                       13'($urandom_range(8191)) : 13'($urandom_range(12)));
      end
      if ($urandom_range(3) == 0) write_register(CFG_BPP, 13'($urandom_range(8191)));
      burst = $urandom_range(20, 120);
      for (int i = 0; i < burst; i++) begin
        // A fresh image is forced where the next word would read stale line store.
        start = (i == 0 && $urandom_range(1) == 0) || ($urandom_range(49) == 0) ||
                reads_unwritten();
        if (start || want_filter) begin
          x = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(FILTER_MAX_CODE));
        end else begin
          x = 8'($urandom);
        end
        send_byte(x, start);
        sent++;
      end
    end
    wait_idle();
    quiet <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_default_row();
    test_each_filter();
    test_image_restart();
    test_register_limits();
    test_midrow_registers();
    test_output_backpressure();
    test_random_streams();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
